@@ hdl/mhbi_pkg.sv @@
// Package for the multi-hash bucket index unit: sizes, codes, shared types
// and the address shift helper. Depends on nothing.
`default_nettype none

package mhbi_pkg;

   localparam int NUM_HASHES      = 4;
   localparam int ADDR_BITS       = 32;
   localparam int MAX_BUCKET_BITS = 16;
   localparam int MATRIX_ROWS     = 32;

   localparam int BUCKET_W   = 18;
   localparam int SHIFT_W    = 7;
   localparam int KIND_W     = 2;
   localparam int ARG_W      = 6;
   localparam int SEL_W      = 2;
   localparam int ROW_W      = 5;
   localparam int CNT_W      = $clog2(NUM_HASHES + 1);
   localparam int IDX_W      = $clog2(NUM_HASHES);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 24;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   localparam logic [KIND_W-1:0] KIND_SIMPLE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_XOR    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SHIFT  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_MATRIX = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SHIFT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_BITS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PARTITIONED = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_COUNT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_KINDS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_ARGS   = 3'd5;

   typedef struct packed {
      logic [4:0]  base_shift;
      logic [4:0]  bucket_bits;
      logic        partitioned;
      logic [2:0]  hash_count;
      logic [7:0]  hash_kinds;
      logic [23:0] hash_args;
   } cfg_type;

   typedef struct packed {
      logic [NUM_HASHES-1:0]               en;
      logic [NUM_HASHES-1:0][BUCKET_W-1:0] val;
   } hash_set_type;

   typedef struct packed {
      logic [CNT_W-1:0]                    count;
      logic [NUM_HASHES-1:0][BUCKET_W-1:0] val;
   } bucket_list_type;

   function automatic logic [ADDR_BITS-1:0] shr(input logic [ADDR_BITS-1:0] a,
                                                input logic [SHIFT_W-1:0]   s);
      logic [ADDR_BITS-1:0] r;
      if (s >= SHIFT_W'(ADDR_BITS)) begin
         r = '0;
      end else begin
         r = a >> s;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hdl/multi_hash_bucket_index_unit.sv @@
// Multi-hash bucket index unit: accepts one request transaction per cycle when
// not stalled and returns the distinct bucket numbers of each lookup in ascending
// order. Depends on mhbi_pkg, mhbi_hash, mhbi_sort and mhbi_emit.
//
// A request enters every cycle while the result side keeps up and the output
// register is free. A lookup passes five register stages (capture, address
// shifts, matrix XOR and mask, sort, output); it then holds the output register
// until each of its distinct buckets, one to four, has been sent, and the next
// lookup enters that register only once its last bucket is taken. A load
// transaction writes one H3 matrix row when it reaches the matrix stage, so a
// lookup accepted in the next cycle already sees the new row, and it emits
// nothing. A lookup with a hash count of zero emits nothing either. The 128
// matrix rows sit in flip-flops that reset clears; no clearing pass follows
// reset. The user writes registers through the csr_ port only while the unit
// is idle; the unit itself does not enforce this.
`default_nettype none

module multi_hash_bucket_index_unit
   import mhbi_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // address[31:0], hash_select[33:32], row_index[38:34], row_value[54:39], zero
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // cmd[0]
   input  wire logic                   req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // bucket[17:0], zero
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                        rsp_tlast,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type         cfg_ff;
   logic            hash_valid;
   logic            hash_ready;
   hash_set_type    hash_set;
   logic            sort_valid;
   logic            sort_ready;
   bucket_list_type sort_list;
   logic [BUCKET_W-1:0] bucket;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_shift  <= 5'd6;
         cfg_ff.bucket_bits <= 5'd10;
         cfg_ff.partitioned <= 1'b0;
         cfg_ff.hash_count  <= 3'd1;
         cfg_ff.hash_kinds  <= '0;
         cfg_ff.hash_args   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BASE_SHIFT:  cfg_ff.base_shift  <= csr_wdata[4:0];
            CSR_BUCKET_BITS: cfg_ff.bucket_bits <= csr_wdata[4:0];
            CSR_PARTITIONED: cfg_ff.partitioned <= csr_wdata[0];
            CSR_HASH_COUNT:  cfg_ff.hash_count  <= csr_wdata[2:0];
            CSR_HASH_KINDS:  cfg_ff.hash_kinds  <= csr_wdata[7:0];
            CSR_HASH_ARGS:   cfg_ff.hash_args   <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   mhbi_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (req_tuser),
      .in_addr   (req_tdata[31:0]),
      .in_sel    (req_tdata[33:32]),
      .in_row    (req_tdata[38:34]),
      .in_value  (req_tdata[54:39]),
      .out_valid (hash_valid),
      .out_ready (hash_ready),
      .out_set   (hash_set)
   );

   mhbi_sort u_sort (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hash_valid),
      .in_ready  (hash_ready),
      .in_set    (hash_set),
      .out_valid (sort_valid),
      .out_ready (sort_ready),
      .out_list  (sort_list)
   );

   mhbi_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (sort_valid),
      .in_ready   (sort_ready),
      .in_list    (sort_list),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_bucket (bucket),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_TDATA_W-BUCKET_W)'(0), bucket};

endmodule

`default_nettype wire

@@ hdl/mhbi_hash.sv @@
// Hash stages of the multi-hash bucket index unit: address shifts, H3 matrix
// store and XOR tree, mask and partition offset. Depends on mhbi_pkg.
`default_nettype none

module mhbi_hash
   import mhbi_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cfg_type              cfg,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic                 in_cmd,
   input  wire logic [ADDR_BITS-1:0] in_addr,
   input  wire logic [SEL_W-1:0]     in_sel,
   input  wire logic [ROW_W-1:0]     in_row,
   input  wire logic [MAX_BUCKET_BITS-1:0] in_value,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output hash_set_type              out_set
);

   logic                       s1_v_ff;
   logic                       s1_cmd_ff;
   logic [ADDR_BITS-1:0]       s1_addr_ff;
   logic [SEL_W-1:0]           s1_sel_ff;
   logic [ROW_W-1:0]           s1_row_ff;
   logic [MAX_BUCKET_BITS-1:0] s1_value_ff;

   logic                       s2_v_ff;
   logic                       s2_cmd_ff;
   logic [MATRIX_ROWS-1:0]     s2_b_ff;
   logic [NUM_HASHES-1:0][MAX_BUCKET_BITS-1:0] s2_pre_ff;
   logic [NUM_HASHES-1:0][MAX_BUCKET_BITS-1:0] s2_pre_in;
   logic [SEL_W-1:0]           s2_sel_ff;
   logic [ROW_W-1:0]           s2_row_ff;
   logic [MAX_BUCKET_BITS-1:0] s2_value_ff;

   logic                       s3_v_ff;
   hash_set_type               s3_set_ff;
   hash_set_type               s3_set_in;

   logic [MAX_BUCKET_BITS-1:0] matrix_ff [NUM_HASHES][MATRIX_ROWS];

   logic [ADDR_BITS-1:0]       base_val;
   logic                       s1_ready;
   logic                       s2_ready;
   logic                       s3_ready;

   assign s3_ready = !s3_v_ff || out_ready;
   assign s2_ready = !s2_v_ff || (s2_cmd_ff == CMD_LOAD) || s3_ready;
   assign s1_ready = !s1_v_ff || s2_ready;
   assign in_ready = s1_ready;

   assign base_val = shr(s1_addr_ff, {2'b00, cfg.base_shift});

   always_comb begin
      logic [KIND_W-1:0]    kind;
      logic [ARG_W-1:0]     arg;
      logic [ADDR_BITS-1:0] xs;
      logic [ADDR_BITS-1:0] ss;
      for (int i = 0; i < NUM_HASHES; i++) begin
         kind = cfg.hash_kinds[KIND_W*i +: KIND_W];
         arg  = cfg.hash_args[ARG_W*i +: ARG_W];
         xs   = shr(s1_addr_ff, {1'b0, arg});
         ss   = shr(s1_addr_ff, SHIFT_W'({2'b00, cfg.base_shift}) + SHIFT_W'(arg));
         unique case (kind)
            KIND_XOR:   s2_pre_in[i] = xs[MAX_BUCKET_BITS-1:0] ^
                                       base_val[MAX_BUCKET_BITS-1:0];
            KIND_SHIFT: s2_pre_in[i] = ss[MAX_BUCKET_BITS-1:0];
            default:    s2_pre_in[i] = base_val[MAX_BUCKET_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      logic [4:0]                 bb;
      logic [MAX_BUCKET_BITS:0]   mask_wide;
      logic [MAX_BUCKET_BITS-1:0] mask;
      logic [MAX_BUCKET_BITS-1:0] mx;
      logic [MAX_BUCKET_BITS-1:0] h;
      logic [2:0]                 n;
      bb = (cfg.bucket_bits > 5'(MAX_BUCKET_BITS)) ? 5'(MAX_BUCKET_BITS) : cfg.bucket_bits;
      mask_wide = ((MAX_BUCKET_BITS+1)'(1) << bb) - (MAX_BUCKET_BITS+1)'(1);
      mask = mask_wide[MAX_BUCKET_BITS-1:0];
      n = (cfg.hash_count > 3'(NUM_HASHES)) ? 3'(NUM_HASHES) : cfg.hash_count;
      for (int i = 0; i < NUM_HASHES; i++) begin
         mx = '0;
         for (int j = 0; j < MATRIX_ROWS; j++) begin
            mx = mx ^ (s2_b_ff[j] ? matrix_ff[i][j] : '0);
         end
         if (cfg.hash_kinds[KIND_W*i +: KIND_W] == KIND_MATRIX) begin
            h = mx & mask;
         end else begin
            h = s2_pre_ff[i] & mask;
         end
         s3_set_in.val[i] = BUCKET_W'(h) |
                            (cfg.partitioned ? (BUCKET_W'(i) << bb) : '0);
         s3_set_in.en[i]  = 3'(i) < n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         for (int i = 0; i < NUM_HASHES; i++) begin
            for (int j = 0; j < MATRIX_ROWS; j++) begin
               matrix_ff[i][j] <= '0;
            end
         end
      end else begin
         if (s1_ready) begin
            s1_v_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_ready) begin
            s3_v_ff <= s2_v_ff && (s2_cmd_ff == CMD_LOOKUP);
         end
         if (s2_v_ff && (s2_cmd_ff == CMD_LOAD)) begin
            matrix_ff[s2_sel_ff][s2_row_ff] <= s2_value_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_cmd_ff   <= in_cmd;
         s1_addr_ff  <= in_addr;
         s1_sel_ff   <= in_sel;
         s1_row_ff   <= in_row;
         s1_value_ff <= in_value;
      end
      if (s2_ready && s1_v_ff) begin
         s2_cmd_ff   <= s1_cmd_ff;
         s2_b_ff     <= base_val[MATRIX_ROWS-1:0];
         s2_pre_ff   <= s2_pre_in;
         s2_sel_ff   <= s1_sel_ff;
         s2_row_ff   <= s1_row_ff;
         s2_value_ff <= s1_value_ff;
      end
      if (s3_ready && s2_v_ff && (s2_cmd_ff == CMD_LOOKUP)) begin
         s3_set_ff <= s3_set_in;
      end
   end

   assign out_valid = s3_v_ff;
   assign out_set   = s3_set_ff;

endmodule

`default_nettype wire

@@ hdl/mhbi_sort.sv @@
// Sort stage of the multi-hash bucket index unit: drop repeated buckets and
// place the rest in ascending order. Depends on mhbi_pkg.
`default_nettype none

module mhbi_sort
   import mhbi_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire hash_set_type in_set,
   output logic              out_valid,
   input  wire logic         out_ready,
   output bucket_list_type   out_list
);

   logic            v_ff;
   bucket_list_type list_ff;
   bucket_list_type list_in;
   logic            ready;

   assign ready    = !v_ff || out_ready;
   assign in_ready = ready;

   always_comb begin
      logic [NUM_HASHES-1:0] keep;
      logic [CNT_W-1:0]      rank;
      logic [CNT_W-1:0]      cnt;
      keep = '0;
      cnt  = '0;
      list_in.val = '0;
      for (int i = 0; i < NUM_HASHES; i++) begin
         keep[i] = in_set.en[i];
         for (int j = 0; j < i; j++) begin
            if (in_set.en[j] && (in_set.val[j] == in_set.val[i])) begin
               keep[i] = 1'b0;
            end
         end
      end
      for (int i = 0; i < NUM_HASHES; i++) begin
         rank = '0;
         for (int j = 0; j < NUM_HASHES; j++) begin
            if (keep[j] && (in_set.val[j] < in_set.val[i])) begin
               rank = rank + CNT_W'(1);
            end
         end
         if (keep[i]) begin
            list_in.val[rank[IDX_W-1:0]] = in_set.val[i];
            cnt = cnt + CNT_W'(1);
         end
      end
      list_in.count = cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (ready) begin
         v_ff <= in_valid && (list_in.count != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (ready && in_valid) begin
         list_ff <= list_in;
      end
   end

   assign out_valid = v_ff;
   assign out_list  = list_ff;

endmodule

`default_nettype wire

@@ hdl/mhbi_emit.sv @@
// Output stage of the multi-hash bucket index unit: send the sorted buckets
// one transaction each, marking the final one. Depends on mhbi_pkg.
`default_nettype none

module mhbi_emit
   import mhbi_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire bucket_list_type in_list,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output logic [BUCKET_W-1:0]  out_bucket,
   output logic                 out_last
);

   logic             v_ff;
   bucket_list_type  list_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic             fire;

   assign out_valid  = v_ff;
   assign out_bucket = list_ff.val[idx_ff];
   assign out_last   = ({1'b0, idx_ff} == (list_ff.count - CNT_W'(1)));
   assign fire       = v_ff && out_ready;
   assign in_ready   = !v_ff || (fire && out_last);
   assign idx_in     = in_ready ? '0 : (fire ? idx_ff + IDX_W'(1) : idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff   <= 1'b0;
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         if (in_ready) begin
            v_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         list_ff <= in_list;
      end
   end

endmodule

`default_nettype wire

@@ tb/multi_hash_bucket_index_unit_tb.sv @@
// Testbench for multi_hash_bucket_index_unit: directed and random lookup and
// matrix load transactions, with bucket lists predicted by a scoreboard class.
// Depends on mhbi_pkg and the unit itself.
`timescale 1ns / 1ps

import mhbi_pkg::*;

class bucket_index_tracker;
   typedef struct packed {
      logic [BUCKET_W-1:0] bucket;
      logic                last;
   } bucket_entry_type;

   logic [4:0]  shift_base;
   logic [4:0]  bits_per_hash;
   logic        split_ranges;
   logic [2:0]  hashes_used;
   logic [7:0]  kind_sel;
   logic [23:0] arg_sel;
   logic [15:0] h3_rows [NUM_HASHES*MATRIX_ROWS];
   bucket_entry_type awaited[$];
   int unsigned failures;

   function new();
      shift_base    = 5'd6;
      bits_per_hash = 5'd10;
      split_ranges  = 1'b0;
      hashes_used   = 3'd1;
      kind_sel      = '0;
      arg_sel       = '0;
      foreach (h3_rows[k]) h3_rows[k] = '0;
      failures = 0;
   endfunction

   function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_BASE_SHIFT:  shift_base    = data[4:0];
         CSR_BUCKET_BITS: bits_per_hash = data[4:0];
         CSR_PARTITIONED: split_ranges  = data[0];
         CSR_HASH_COUNT:  hashes_used   = data[2:0];
         CSR_HASH_KINDS:  kind_sel      = data[7:0];
         CSR_HASH_ARGS:   arg_sel       = data[23:0];
         default: ;
      endcase
   endfunction

   function logic [ADDR_BITS-1:0] addr_shift(logic [ADDR_BITS-1:0] a, int unsigned s);
      if (s >= ADDR_BITS) return '0;
      return a >> s;
   endfunction

   function int unsigned pending_count();
      return awaited.size();
   endfunction

   function void note_request(logic cmd, logic [31:0] addr, logic [1:0] sel,
                              logic [4:0] row, logic [15:0] val);
      logic [BUCKET_W-1:0] found[$];
      logic [BUCKET_W-1:0] v;
      logic [31:0]         b, h, mask;
      logic [KIND_W-1:0]   kind;
      logic [ARG_W-1:0]    arg;
      int unsigned         bb, n, i, j, k;
      bit                  dup;
      bucket_entry_type    e;
      if (cmd == CMD_LOAD) begin
         h3_rows[sel*MATRIX_ROWS + row] = val;
         return;
      end
      bb   = (bits_per_hash > MAX_BUCKET_BITS) ? MAX_BUCKET_BITS : bits_per_hash;
      n    = (hashes_used > NUM_HASHES) ? NUM_HASHES : hashes_used;
      mask = (32'd1 << bb) - 32'd1;
      b    = addr_shift(addr, 32'(shift_base));
      for (i = 0; i < n; i++) begin
         kind = kind_sel[2*i +: 2];
         arg  = arg_sel[6*i +: 6];
         case (kind)
            KIND_SIMPLE: h = b;
            KIND_XOR:    h = b ^ addr_shift(addr, 32'(arg));
            KIND_SHIFT:  h = addr_shift(addr, 32'(shift_base) + 32'(arg));
            default: begin
               h = '0;
               for (j = 0; j < MATRIX_ROWS; j++)
                  if (b[j]) h = h ^ {16'd0, h3_rows[i*MATRIX_ROWS + j]};
            end
         endcase
         v = BUCKET_W'(h & mask);
         if (split_ranges) v = v + BUCKET_W'(i << bb);
         dup = 1'b0;
         foreach (found[q]) if (found[q] == v) dup = 1'b1;
         if (!dup) begin
            k = 0;
            while (k < found.size() && found[k] < v) k++;
            found.insert(k, v);
         end
      end
      foreach (found[q]) begin
         e.bucket = found[q];
         e.last   = (q == found.size() - 1);
         awaited.insert(awaited.size(), e);
      end
   endfunction

   function void check_bucket(logic [BUCKET_W-1:0] bucket, logic last);
      bucket_entry_type e;
      if (awaited.size() == 0) begin
         $display("%0t: unexpected transaction, expected none, actual bucket %0h last %0b",
                  $time, bucket, last);
         failures++;
         return;
      end
      e = awaited.pop_front();
      if (bucket !== e.bucket) begin
         $display("%0t: bucket mismatch, expected %0h, actual %0h", $time, e.bucket, bucket);
         failures++;
      end
      if (last !== e.last) begin
         $display("%0t: last mismatch, expected %0b, actual %0b", $time, e.last, last);
         failures++;
      end
   endfunction
endclass

module multi_hash_bucket_index_unit_tb;

   localparam int SETTLE_CYCLES   = 16;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 2000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   bit no_gaps  = 1'b0;
   bit hold_rsp = 1'b0;

   bucket_index_tracker tracker = new();

   multi_hash_bucket_index_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_req(input logic cmd, input logic [31:0] addr, input logic [1:0] sel,
                           input logic [4:0] row, input logic [15:0] val);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, val, row, sel, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_request(cmd, addr, sel, row, val);
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic lookup(input logic [31:0] addr);
      send_req(CMD_LOOKUP, addr, 2'($urandom), 5'($urandom), 16'($urandom));
   endtask

   task automatic load_row(input logic [1:0] sel, input logic [4:0] row, input logic [15:0] val);
      send_req(CMD_LOAD, $urandom, sel, row, val);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.pending_count() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      tracker.write_reg(index, data);
   endtask

   task automatic apply_config(input logic [4:0] shift_v, input logic [4:0] bits_v,
                               input logic part_v, input logic [2:0] count_v,
                               input logic [7:0] kinds_v, input logic [23:0] args_v);
      drain();
      csr_write(CSR_BASE_SHIFT, CSR_DATA_W'(shift_v));
      csr_write(CSR_BUCKET_BITS, CSR_DATA_W'(bits_v));
      csr_write(CSR_PARTITIONED, CSR_DATA_W'(part_v));
      csr_write(CSR_HASH_COUNT, CSR_DATA_W'(count_v));
      csr_write(CSR_HASH_KINDS, CSR_DATA_W'(kinds_v));
      csr_write(CSR_HASH_ARGS, args_v);
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_bucket(rsp_tdata[BUCKET_W-1:0], rsp_tlast);
   end

   initial begin : rsp_pacing
      int unsigned n;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            // hold off the result side so the unit backs up into the request side
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            n = $urandom_range(1, 24);
            repeat (n) @(posedge clock);
            n = idle_gap();
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_wr_en || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle = 0;
         else
            idle++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      logic [4:0]  shift_v, bits_v;
      logic        part_v;
      logic [2:0]  count_v;
      logic [7:0]  kinds_v;
      logic [23:0] args_v;
      logic [31:0] addr;
      int unsigned phase, item, pick, f;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      lookup(32'h0000_0000);
      send_req(CMD_LOOKUP, 32'hFFFF_FFFF, 2'd3, 5'd31, 16'hFFFF);
      load_row(2'd0, 5'd0, 16'hFFFF);
      load_row(2'd3, 5'd31, 16'hFFFF);
      load_row(2'd3, 5'd0, 16'h0001);
      load_row(2'd1, 5'd5, 16'hA5A5);
      load_row(2'd2, 5'd31, 16'h8000);
      send_req(CMD_LOAD, 32'hFFFF_FFFF, 2'd0, 5'd1, 16'h0000);

      apply_config(5'd0, 5'd16, 1'b1, 3'd4, {KIND_MATRIX, KIND_SHIFT, KIND_XOR, KIND_SIMPLE},
                   {6'd0, 6'd31, 6'd63, 6'd0});
      lookup(32'hFFFF_FFFF);
      lookup(32'h0000_0000);
      lookup(32'h8000_0001);
      lookup(32'h0000_0021);

      apply_config(5'd31, 5'd0, 1'b1, 3'd7, 8'hFF, 24'hFF_FFFF);
      lookup(32'hFFFF_FFFF);
      lookup(32'h8000_0000);

      apply_config(5'd31, 5'd31, 1'b0, 3'd0, 8'h00, 24'h00_0000);
      lookup(32'hFFFF_FFFF);

      apply_config(5'd5, 5'd1, 1'b0, 3'd4, 8'h00, 24'h00_0000);
      lookup(32'h1234_5678);

      apply_config(5'd0, 5'd16, 1'b0, 3'd4, 8'hFF, 24'h00_0000);
      lookup(32'h8000_0001);
      lookup(32'hFFFF_FFFF);

      for (phase = 0; phase < 9; phase++) begin
         if ($urandom_range(0, 3) == 0) shift_v = $urandom_range(0, 1) ? 5'd31 : 5'd0;
         else shift_v = 5'($urandom_range(0, 20));
         if ($urandom_range(0, 9) == 0)
            bits_v = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
         else bits_v = 5'($urandom_range(1, 16));
         part_v = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 6) == 0)
            count_v = $urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(5, 7));
         else count_v = 3'($urandom_range(1, 4));
         kinds_v = 8'($urandom);
         for (f = 0; f < 4; f++)
            args_v[6*f +: 6] = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(32, 63))
                                                          : 6'($urandom_range(0, 31));
         if (phase == 6) count_v = 3'd4;
         apply_config(shift_v, bits_v, part_v, count_v, kinds_v, args_v);

         no_gaps = (phase == 3) || (phase == 6);
         if (phase == 6) hold_rsp = 1'b1;
         for (item = 0; item < 55; item++) begin
            pick = $urandom_range(0, 99);
            if (pick < 20 && phase != 6) begin
               load_row(2'($urandom), 5'($urandom),
                        ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom));
            end else begin
               pick = $urandom_range(0, 9);
               if (pick < 6) addr = $urandom;
               else if (pick < 8) addr = 32'($urandom_range(0, 4095)) << shift_v;
               else if (pick < 9) addr = 32'h1 << $urandom_range(0, 31);
               else addr = 32'hFFFF_FFFF;
               lookup(addr);
            end
         end
         no_gaps = 1'b0;
      end

      drain();
      if (tracker.failures == 0 && tracker.pending_count() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
